[rtl/core/tws_pkg.sv]
package tws_pkg;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_NEG,
		PH_CHUNK,
		PH_ACK,
		PH_DONE,
		PH_FAIL
	} phase_t;

	localparam logic [2:0] ACT_NONE = 3'd0;
	localparam logic [2:0] ACT_REQ  = 3'd1;
	localparam logic [2:0] ACT_DATA = 3'd2;
	localparam logic [2:0] ACT_NEED = 3'd3;
	localparam logic [2:0] ACT_DONE = 3'd4;
	localparam logic [2:0] ACT_FAIL = 3'd5;

	localparam logic [1:0] FUNC_START   = 2'd0;
	localparam logic [1:0] FUNC_RESP    = 2'd1;
	localparam logic [1:0] FUNC_TIMEOUT = 2'd2;
	localparam logic [1:0] FUNC_CHUNK   = 2'd3;

	localparam logic [7:0] OP_ACK   = 8'd4;
	localparam logic [7:0] OP_ERROR = 8'd5;
	localparam logic [7:0] OP_OACK  = 8'd6;

	localparam logic [2:0] RSN_NONE    = 3'd0;
	localparam logic [2:0] RSN_SHORT   = 3'd1;
	localparam logic [2:0] RSN_PEER    = 3'd2;
	localparam logic [2:0] RSN_OPCODE  = 3'd3;
	localparam logic [2:0] RSN_RETRIES = 3'd4;

	localparam logic [15:0] FALLBACK_SIZE = 16'd512;
	localparam logic [15:0] SIZE_MIN      = 16'd8;
	localparam logic [15:0] SIZE_MAX      = 16'd65464;

	localparam logic [15:0] CFG_BLOCK_SIZE_RST = 16'd512;
	localparam logic [7:0]  CFG_RETRY_RST      = 8'd5;

	typedef struct packed {
		phase_t      phase;
		logic [15:0] cur_block;
		logic [7:0]  retries;
		logic [15:0] act_size;
		logic [15:0] pend_len;
	} xfer_state_t;

	typedef struct packed {
		logic [1:0]  func;
		logic [7:0]  resp_opcode;
		logic [15:0] resp_value;
		logic        resp_short;
		logic [15:0] chunk_length;
	} event_t;

	typedef struct packed {
		logic [2:0]  action;
		logic [15:0] block_number;
		logic [15:0] data_length;
		logic [15:0] negotiated_size;
		logic [2:0]  fail_reason;
		logic [15:0] fail_value;
	} result_t;

endpackage

[rtl/core/tws_step.sv]
module tws_step (
	input  tws_pkg::xfer_state_t st,
	input  tws_pkg::event_t      ev,
	input  logic [15:0]          block_size_cfg,
	input  logic [7:0]           retry_limit,
	output tws_pkg::xfer_state_t st_nxt,
	output tws_pkg::result_t     res
);

	logic [2:0]  act;
	logic [2:0]  rsn;
	logic [15:0] fval;
	logic [15:0] oack_size;
	logic [15:0] clamp_len;

	always_comb begin
		if (block_size_cfg < tws_pkg::SIZE_MIN) begin
			oack_size = tws_pkg::SIZE_MIN;
		end else if (block_size_cfg > tws_pkg::SIZE_MAX) begin
			oack_size = tws_pkg::SIZE_MAX;
		end else begin
			oack_size = block_size_cfg;
		end
		clamp_len = (ev.chunk_length > st.act_size) ? st.act_size : ev.chunk_length;
	end

	always_comb begin
		st_nxt = st;
		act    = tws_pkg::ACT_NONE;
		rsn    = tws_pkg::RSN_NONE;
		fval   = 16'd0;
		if (ev.func == tws_pkg::FUNC_START) begin
			st_nxt.phase     = tws_pkg::PH_NEG;
			st_nxt.cur_block = 16'd1;
			st_nxt.retries   = retry_limit;
			st_nxt.act_size  = 16'd0;
			st_nxt.pend_len  = 16'd0;
			act              = tws_pkg::ACT_REQ;
		end else begin
			case (st.phase)
				tws_pkg::PH_NEG: begin
					if (ev.func == tws_pkg::FUNC_TIMEOUT) begin
						act = tws_pkg::ACT_FAIL;
						rsn = tws_pkg::RSN_RETRIES;
					end else if (ev.func == tws_pkg::FUNC_RESP) begin
						if (ev.resp_short) begin
							act = tws_pkg::ACT_FAIL;
							rsn = tws_pkg::RSN_SHORT;
						end else if (ev.resp_opcode == tws_pkg::OP_OACK) begin
							st_nxt.act_size = oack_size;
							act             = tws_pkg::ACT_NEED;
						end else if (ev.resp_opcode == tws_pkg::OP_ACK) begin
							st_nxt.act_size = tws_pkg::FALLBACK_SIZE;
							act             = tws_pkg::ACT_NEED;
						end else if (ev.resp_opcode == tws_pkg::OP_ERROR) begin
							act  = tws_pkg::ACT_FAIL;
							rsn  = tws_pkg::RSN_PEER;
							fval = ev.resp_value;
						end else begin
							act  = tws_pkg::ACT_FAIL;
							rsn  = tws_pkg::RSN_OPCODE;
							fval = {8'd0, ev.resp_opcode};
						end
						if (act == tws_pkg::ACT_NEED) begin
							st_nxt.phase = tws_pkg::PH_CHUNK;
						end
					end
				end
				tws_pkg::PH_CHUNK: begin
					if (ev.func == tws_pkg::FUNC_CHUNK) begin
						st_nxt.pend_len = clamp_len;
						st_nxt.phase    = tws_pkg::PH_ACK;
						act             = tws_pkg::ACT_DATA;
					end
				end
				tws_pkg::PH_ACK: begin
					if (ev.func == tws_pkg::FUNC_TIMEOUT || (ev.func == tws_pkg::FUNC_RESP
							&& !ev.resp_short && ev.resp_opcode == tws_pkg::OP_ACK
							&& ev.resp_value != st.cur_block)) begin
						// spend one retry; a budget of zero or one is used up here
						if (st.retries <= 8'd1) begin
							st_nxt.retries = 8'd0;
							act            = tws_pkg::ACT_FAIL;
							rsn            = tws_pkg::RSN_RETRIES;
						end else begin
							st_nxt.retries = st.retries - 8'd1;
							act            = tws_pkg::ACT_DATA;
						end
					end else if (ev.func == tws_pkg::FUNC_RESP) begin
						if (ev.resp_short) begin
							act = tws_pkg::ACT_FAIL;
							rsn = tws_pkg::RSN_SHORT;
						end else if (ev.resp_opcode == tws_pkg::OP_ACK) begin
							st_nxt.cur_block = st.cur_block + 16'd1;
							if (st.pend_len == st.act_size) begin
								st_nxt.phase = tws_pkg::PH_CHUNK;
								act          = tws_pkg::ACT_NEED;
							end else begin
								st_nxt.phase = tws_pkg::PH_DONE;
								act          = tws_pkg::ACT_DONE;
							end
						end else if (ev.resp_opcode == tws_pkg::OP_ERROR) begin
							act  = tws_pkg::ACT_FAIL;
							rsn  = tws_pkg::RSN_PEER;
							fval = ev.resp_value;
						end else begin
							act  = tws_pkg::ACT_FAIL;
							rsn  = tws_pkg::RSN_OPCODE;
							fval = {8'd0, ev.resp_opcode};
						end
					end
				end
				default: begin
					act = tws_pkg::ACT_NONE;
				end
			endcase
			if (act == tws_pkg::ACT_FAIL) begin
				st_nxt.phase = tws_pkg::PH_FAIL;
			end
		end
	end

	// block number and length reflect the state after the event
	always_comb begin
		res.action          = act;
		res.block_number    = (act == tws_pkg::ACT_DATA) ? st_nxt.cur_block : 16'd0;
		res.data_length     = (act == tws_pkg::ACT_DATA) ? st_nxt.pend_len : 16'd0;
		res.negotiated_size = st_nxt.act_size;
		res.fail_reason     = rsn;
		res.fail_value      = fval;
	end

endmodule

[rtl/core/tftp_write_sender_control.sv]
// channel | handshake                  | payload
// item    | item_valid / item_stall    | func, resp_opcode, resp_value, resp_short, chunk_length
// result  | result_valid / result_stall| action, block_number, data_length, negotiated_size,
//         |                            | fail_reason, fail_value
// config  | APB write/read, pready = 1 | 0x0 block_size_cfg, 0x4 retry_limit
//
// One event per cycle sustained while result_stall is low; an accepted event passes through
// the input register, then one pass of the event logic into the result register.
// The result register frees the input side: a new word is taken while a result waits.
// item_stall rises only when the input register is full and the result register is held.
// arst_n clears control state and loads the register reset values; no clearing pass.
module tftp_write_sender_control (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [1:0]  func,
	input  logic [7:0]  resp_opcode,
	input  logic [15:0] resp_value,
	input  logic        resp_short,
	input  logic [15:0] chunk_length,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [2:0]  action,
	output logic [15:0] block_number,
	output logic [15:0] data_length,
	output logic [15:0] negotiated_size,
	output logic [2:0]  fail_reason,
	output logic [15:0] fail_value
);

	logic [15:0]          block_size_cfg_q;
	logic [7:0]           retry_limit_q;
	tws_pkg::xfer_state_t st_q;
	tws_pkg::xfer_state_t st_nxt;
	tws_pkg::event_t      ev_s1;
	logic                 valid_s1;
	tws_pkg::result_t     res_nxt;
	tws_pkg::result_t     res_q;
	logic                 res_valid_q;
	logic                 advance;
	logic                 take;
	logic                 cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = paddr[2] ? {24'd0, retry_limit_q} : {16'd0, block_size_cfg_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_size_cfg_q <= tws_pkg::CFG_BLOCK_SIZE_RST;
			retry_limit_q    <= tws_pkg::CFG_RETRY_RST;
		end else if (cfg_wr) begin
			if (paddr[2]) begin
				retry_limit_q <= pwdata[7:0];
			end else begin
				block_size_cfg_q <= pwdata[15:0];
			end
		end
	end

	assign advance    = valid_s1 && (!res_valid_q || !result_stall);
	assign item_stall = valid_s1 && !advance;
	assign take       = item_valid && !item_stall;

	tws_step u_step (
		.st             (st_q),
		.ev             (ev_s1),
		.block_size_cfg (block_size_cfg_q),
		.retry_limit    (retry_limit_q),
		.st_nxt         (st_nxt),
		.res            (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1        <= 1'b0;
			res_valid_q     <= 1'b0;
			st_q.phase      <= tws_pkg::PH_IDLE;
			st_q.cur_block  <= 16'd1;
			st_q.retries    <= 8'd0;
			st_q.act_size   <= 16'd0;
			st_q.pend_len   <= 16'd0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				res_valid_q <= 1'b1;
				st_q        <= st_nxt;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ev_s1.func         <= func;
			ev_s1.resp_opcode  <= resp_opcode;
			ev_s1.resp_value   <= resp_value;
			ev_s1.resp_short   <= resp_short;
			ev_s1.chunk_length <= chunk_length;
		end
		// hold the word while the consumer stalls
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	assign result_valid    = res_valid_q;
	assign action          = res_q.action;
	assign block_number    = res_q.block_number;
	assign data_length     = res_q.data_length;
	assign negotiated_size = res_q.negotiated_size;
	assign fail_reason     = res_q.fail_reason;
	assign fail_value      = res_q.fail_value;

	a_len_in_size: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.action == tws_pkg::ACT_DATA)
			|-> (res_q.data_length <= res_q.negotiated_size))
		else $error("data length exceeds negotiated size");

	a_reason_only_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.action != tws_pkg::ACT_FAIL)
			|-> (res_q.fail_reason == tws_pkg::RSN_NONE && res_q.fail_value == 16'd0))
		else $error("fail fields set without failure");

	a_size_set: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.phase == tws_pkg::PH_CHUNK || st_q.phase == tws_pkg::PH_ACK
			|| st_q.phase == tws_pkg::PH_DONE) |-> (st_q.act_size >= tws_pkg::SIZE_MIN))
		else $error("transfer phase without negotiated size");

	a_no_state_move_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(st_q))
		else $error("state changed without an event");

endmodule
